### rtl/drtm_pkg.sv
package drtm_pkg;

  // field and datapath widths
  localparam int VAL_W   = 16;
  localparam int SQ_W    = 32;
  localparam int SUM_W   = 48;
  localparam int SLOT_W  = 12;
  localparam int RATIO_W = 16;
  localparam int HALF_W  = SUM_W / 2;
  localparam int PROD_W  = RATIO_W + HALF_W;
  localparam int CMP_W   = SUM_W + RATIO_W;

  // candidate index saturation
  localparam int MAX_CANDIDATES = 4096;
  localparam int CAND_LIMIT = (MAX_CANDIDATES > 4096) ? 4095 : MAX_CANDIDATES - 1;
  localparam logic [SLOT_W-1:0] CAND_MAX = SLOT_W'(CAND_LIMIT);

  // initial best and second distance
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS = 1'd1;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd39322;

  // stream packing
  localparam int IN_DATA_W  = 2 * VAL_W;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - SLOT_W - SUM_W;

  // accepted element pair
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] q;
    logic signed [VAL_W-1:0] c;
    logic                    same;
    logic                    close;
    logic                    last;
  } in_stage_t;

  // squared difference
  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sq;
    logic            same;
    logic            close;
    logic            last;
  } sq_stage_t;

  // closed candidate distance
  typedef struct packed {
    logic             valid;
    logic             close;
    logic             take;
    logic             last;
    logic [SUM_W-1:0] distance;
  } dist_stage_t;

  // final best and second of a list
  typedef struct packed {
    logic              valid;
    logic              bvalid;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0]  best;
    logic [SUM_W-1:0]  second;
  } final_t;

  // one result
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] index;
    logic [SUM_W-1:0]  distance;
  } result_t;

endpackage

### rtl/drtm_sq.sv
module drtm_sq (
  input  logic                clk,
  input  logic                rst,
  input  drtm_pkg::in_stage_t item,
  output drtm_pkg::sq_stage_t sq_out
);
  import drtm_pkg::*;

  in_stage_t             s0;
  logic signed [VAL_W:0] diff;
  logic        [VAL_W:0] mag_wide;
  logic  [VAL_W-1:0]     mag;
  logic  [SQ_W-1:0]      sq;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0.valid <= item.valid;
    end
    s0.q     <= item.q;
    s0.c     <= item.c;
    s0.same  <= item.same;
    s0.close <= item.close;
    s0.last  <= item.last;
  end

  // magnitude of the difference and its square
  always_comb begin
    diff     = {s0.q[VAL_W-1], s0.q} - {s0.c[VAL_W-1], s0.c};
    mag_wide = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
    mag      = mag_wide[VAL_W-1:0];
    sq       = SQ_W'(mag) * SQ_W'(mag);
  end

  // square register
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_out.valid <= 1'b0;
    end else begin
      sq_out.valid <= s0.valid;
    end
    sq_out.sq    <= sq;
    sq_out.same  <= s0.same;
    sq_out.close <= s0.close;
    sq_out.last  <= s0.last;
  end

endmodule

### rtl/drtm_acc.sv
module drtm_acc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  class_check,
  input  drtm_pkg::sq_stage_t   sq_in,
  output drtm_pkg::dist_stage_t dist_out
);
  import drtm_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  // saturating accumulate
  always_comb begin
    sum_wide = {1'b0, running_sum} + (SUM_W+1)'(sq_in.sq);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  // running sum, cleared when a candidate closes
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (sq_in.valid) begin
      running_sum <= sq_in.close ? '0 : sum_sat;
    end
  end

  // distance register
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_out.valid <= 1'b0;
    end else begin
      dist_out.valid <= sq_in.valid;
    end
    dist_out.close    <= sq_in.close;
    dist_out.take     <= !(class_check && !sq_in.same);
    dist_out.last     <= sq_in.last;
    dist_out.distance <= sum_sat;
  end

endmodule

### rtl/drtm_track.sv
module drtm_track (
  input  logic                  clk,
  input  logic                  rst,
  input  drtm_pkg::dist_stage_t dist_in,
  output drtm_pkg::final_t      fin
);
  import drtm_pkg::*;

  logic [SUM_W-1:0]  best_sum, best_sum_next;
  logic [SUM_W-1:0]  second_sum, second_sum_next;
  logic [SLOT_W-1:0] best_slot, best_slot_next;
  logic [SLOT_W-1:0] candidate_count, candidate_count_next;
  logic              best_valid, best_valid_next;

  // best and second update on a closed candidate
  always_comb begin
    best_sum_next        = best_sum;
    second_sum_next      = second_sum;
    best_slot_next       = best_slot;
    candidate_count_next = candidate_count;
    best_valid_next      = best_valid;
    if (dist_in.valid && dist_in.close) begin
      if (dist_in.take) begin
        if (dist_in.distance < best_sum) begin
          second_sum_next = best_sum;
          best_sum_next   = dist_in.distance;
          best_slot_next  = candidate_count;
          best_valid_next = 1'b1;
        end else if (dist_in.distance < second_sum) begin
          second_sum_next = dist_in.distance;
        end
      end
      if (candidate_count < CAND_MAX) begin
        candidate_count_next = candidate_count + 1'b1;
      end
    end
  end

  // tracking state, back to reset values after the end of a list
  always_ff @(posedge clk) begin
    if (rst || (dist_in.valid && dist_in.last)) begin
      best_sum        <= SUM_MAX;
      second_sum      <= SUM_MAX;
      best_slot       <= '0;
      candidate_count <= '0;
      best_valid      <= 1'b0;
    end else begin
      best_sum        <= best_sum_next;
      second_sum      <= second_sum_next;
      best_slot       <= best_slot_next;
      candidate_count <= candidate_count_next;
      best_valid      <= best_valid_next;
    end
  end

  // final values of the list
  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else begin
      fin.valid <= dist_in.valid && dist_in.last;
    end
    fin.bvalid <= best_valid_next;
    fin.slot   <= best_slot_next;
    fin.best   <= best_sum_next;
    fin.second <= second_sum_next;
  end

endmodule

### rtl/drtm_ratio.sv
module drtm_ratio (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [drtm_pkg::RATIO_W-1:0]  ratio,
  input  drtm_pkg::final_t              fin,
  output logic                          res_valid,
  output drtm_pkg::result_t             res
);
  import drtm_pkg::*;

  logic              v4, v5;
  logic [PROD_W-1:0] p_lo, p_hi;
  logic [SUM_W-1:0]  best4, best5;
  logic [SLOT_W-1:0] slot4, slot5;
  logic              bv4, bv5;
  logic [CMP_W-1:0]  rhs;
  logic [CMP_W-1:0]  lhs;
  logic              found;

  // partial products of ratio times second
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= fin.valid;
    end
    p_lo  <= PROD_W'(ratio) * PROD_W'(fin.second[HALF_W-1:0]);
    p_hi  <= PROD_W'(ratio) * PROD_W'(fin.second[SUM_W-1:HALF_W]);
    best4 <= fin.best;
    slot4 <= fin.slot;
    bv4   <= fin.bvalid;
  end

  // combine partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    rhs   <= {p_hi, {HALF_W{1'b0}}} + CMP_W'(p_lo);
    best5 <= best4;
    slot5 <= slot4;
    bv5   <= bv4;
  end

  // ratio test
  always_comb begin
    lhs          = {best5, {RATIO_W{1'b0}}};
    found        = bv5 && (lhs < rhs);
    res_valid    = v5;
    res.found    = found;
    res.index    = found ? slot5 : '0;
    res.distance = best5;
  end

endmodule

### rtl/drtm_fifo.sv
module drtm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  drtm_pkg::result_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output drtm_pkg::result_t pop_data
);
  import drtm_pkg::*;

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RES_CNT_W'(push) - RES_CNT_W'(pop);
    end
  end

endmodule

### rtl/descriptor_ratio_test_matcher.sv
// Ratio-test matcher: one query descriptor against a list of candidates.
// s_axis carries one element pair per request: tdata holds query_value
// and candidate_value, tuser holds same_class and last_element, and
// tlast marks the final element of the final candidate (last_candidate).
// Each request adds (query - candidate)^2 to a saturating 48-bit sum; a
// candidate closes on last_element or tlast and, if same_class is set or
// class check is off, updates best and second. On tlast the ratio test
// best < ratio_threshold * second is applied and one result request goes
// out on m_axis: tuser = match_found, tdata = match_index, best_distance.
// Throughput is one element per cycle while s_axis_tready is high: the
// accumulator and tracker each take one pipeline stage, the squarer has an
// input and a square register, and the 16x48 multiply takes two. Results
// wait in a 4-entry queue; a counter of results accepted but not yet
// delivered drops s_axis_tready only when 4 results are outstanding, so
// input keeps flowing while m_axis is stalled. cfg_we writes cfg_data to
// register cfg_index (0 ratio_threshold, 1 class_check_enable); the user
// must write only while the block is idle; the block does not enforce it.
// Synchronous reset restores register defaults and clears control state.
module descriptor_ratio_test_matcher (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [drtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drtm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // element pair stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] query_value, [31:16] candidate_value
  input  logic [drtm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] same_class, [1] last_element
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] match_index, [59:12] best_distance, [63:60] zero
  output logic [drtm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] match_found
  output logic                              m_axis_tuser
);
  import drtm_pkg::*;

  logic [RATIO_W-1:0]   ratio_threshold;
  logic                 class_check_enable;
  logic [RES_CNT_W-1:0] pending;
  logic                 in_accept;
  logic                 out_accept;
  in_stage_t            item;
  sq_stage_t            sq_st;
  dist_stage_t          dist_st;
  final_t               fin;
  logic                 res_valid;
  result_t              res;
  result_t              out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_threshold    <= RATIO_RESET;
      class_check_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATIO: ratio_threshold    <= cfg_data[RATIO_W-1:0];
        REG_CLASS: class_check_enable <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // outstanding result count guards the result queue
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (pending < RES_CNT_W'(RES_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + RES_CNT_W'(in_accept && s_axis_tlast)
                         - RES_CNT_W'(out_accept);
    end
  end

  // unpack the request
  always_comb begin
    item.valid = in_accept;
    item.q     = s_axis_tdata[VAL_W-1:0];
    item.c     = s_axis_tdata[2*VAL_W-1:VAL_W];
    item.same  = s_axis_tuser[0];
    item.close = s_axis_tuser[1] || s_axis_tlast;
    item.last  = s_axis_tlast;
  end

  drtm_sq u_sq (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .sq_out (sq_st)
  );

  drtm_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .class_check (class_check_enable),
    .sq_in       (sq_st),
    .dist_out    (dist_st)
  );

  drtm_track u_track (
    .clk     (clk),
    .rst     (rst),
    .dist_in (dist_st),
    .fin     (fin)
  );

  drtm_ratio u_ratio (
    .clk       (clk),
    .rst       (rst),
    .ratio     (ratio_threshold),
    .fin       (fin),
    .res_valid (res_valid),
    .res       (res)
  );

  drtm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop_valid (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .pop_data  (out_res)
  );

  // pack the result
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.distance, out_res.index};
  assign m_axis_tuser = out_res.found;

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drtm_pkg::*;

  // one element pair as driven on the input stream
  typedef struct {
    logic signed [VAL_W-1:0] qv;
    logic signed [VAL_W-1:0] cv;
    logic                    same;
    logic                    close;
    logic                    last;
    logic                    drain;
  } pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [15:0] query_value, [31:16] candidate_value
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] same_class, [1] last_element
  logic [1:0]            s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [11:0] match_index, [59:12] best_distance, [63:60] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] match_found
  logic                  m_axis_tuser;

  descriptor_ratio_test_matcher DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // hard limit on the run
  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // matcher state mirror
  logic [SUM_W-1:0]   ssd_sum = '0;
  logic [SUM_W-1:0]   best_ssd = SUM_MAX;
  logic [SUM_W-1:0]   second_ssd = SUM_MAX;
  logic [SLOT_W-1:0]  best_index = '0;
  logic [SLOT_W-1:0]  cand_index = '0;
  logic               have_best = 1'b0;
  logic [RATIO_W-1:0] ratio_reg = RATIO_RESET;
  logic               class_check_reg = 1'b0;

  pair_t   pair_queue[$];
  result_t pending_matches[$];
  int      mismatch_count = 0;

  // idle control
  int send_pct = 0;
  int recv_pct = 0;
  int send_burst = 0;
  int recv_burst = 0;

  function automatic void clear_query();
    ssd_sum    = '0;
    best_ssd   = SUM_MAX;
    second_ssd = SUM_MAX;
    best_index = '0;
    cand_index = '0;
    have_best  = 1'b0;
  endfunction

  // fold one accepted element pair into the running match search
  function automatic void accumulate_pair(input pair_t p);
    int               diff;
    longint unsigned  mag;
    longint unsigned  sq;
    bit [63:0]        acc;
    bit [63:0]        lhs;
    bit [63:0]        rhs;
    logic [SUM_W-1:0] cand_dist;
    result_t          r;
    diff = int'(p.qv) - int'(p.cv);
    mag  = longint'((diff < 0) ? -diff : diff);
    sq   = mag * mag;
    acc  = 64'(ssd_sum) + sq;
    ssd_sum = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
    // candidate closes on its element mark or on the end of the list
    if (p.close || p.last) begin
      cand_dist = ssd_sum;
      if (!(class_check_reg && !p.same)) begin
        if (cand_dist < best_ssd) begin
          second_ssd = best_ssd;
          best_ssd   = cand_dist;
          best_index = cand_index;
          have_best  = 1'b1;
        end else if (cand_dist < second_ssd) begin
          second_ssd = cand_dist;
        end
      end
      ssd_sum = '0;
      if (cand_index < CAND_MAX) cand_index++;
    end
    // ratio test at the end of the list
    if (p.last) begin
      lhs        = 64'(best_ssd) << 16;
      rhs        = 64'(ratio_reg) * 64'(second_ssd);
      r.found    = have_best && (lhs < rhs);
      r.index    = r.found ? best_index : '0;
      r.distance = best_ssd;
      pending_matches = {pending_matches, r};
      clear_query();
    end
  endfunction

  // random gap with occasional gap-free stretches
  function automatic bit roll_gap(input int pct, inout int burst);
    if (burst > 0) begin
      burst--;
      return 1'b0;
    end
    if ($urandom_range(0, 99) < 2) begin
      burst = $urandom_range(10, 60);
      return 1'b0;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  // request driver
  always @(posedge clk) begin : pair_driver
    pair_t nxt;
    bit    go;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_pair(pair_queue.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        go = (pair_queue.size() > 0) && !roll_gap(send_pct, send_burst);
        // some lists start only once all earlier matches are out
        if (go && pair_queue[0].drain && pending_matches.size() != 0) go = 1'b0;
        if (go) begin
          nxt = pair_queue[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.cv, nxt.qv};
          s_axis_tuser  <= {nxt.close, nxt.same};
          s_axis_tlast  <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : match_monitor
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected result, actual tdata=%h tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = pending_matches.pop_front();
          if (m_axis_tuser !== want.found) begin
            $display("%0t: match_found expected %b actual %b",
                     $time, want.found, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata[SLOT_W-1:0] !== want.index) begin
            $display("%0t: match_index expected %0d actual %0d",
                     $time, want.index, m_axis_tdata[SLOT_W-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[SLOT_W +: SUM_W] !== want.distance) begin
            $display("%0t: best_distance expected %h actual %h",
                     $time, want.distance, m_axis_tdata[SLOT_W +: SUM_W]);
            mismatch_count++;
          end
          if (m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
            $display("%0t: tdata pad expected 0 actual %h",
                     $time, m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= !roll_gap(recv_pct, recv_burst);
    end
  end

  function automatic void push_pair(input int q, input int c, input logic same,
                                    input logic close, input logic last,
                                    input logic drain = 1'b0);
    pair_t p;
    p.qv    = q[VAL_W-1:0];
    p.cv    = c[VAL_W-1:0];
    p.same  = same;
    p.close = close;
    p.last  = last;
    p.drain = drain;
    pair_queue = {pair_queue, p};
  endfunction

  function automatic int rand_value(input bit narrow);
    if (narrow) return int'($urandom_range(0, 400)) - 200;
    case ($urandom_range(0, 19))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // one query against a random candidate list; returns the request count
  function automatic int queue_random_list();
    int   n_cand;
    int   len;
    int   cand_len;
    int   kind;
    int   c;
    int   count;
    int   qvec[16];
    bit   narrow;
    bit   end_cand;
    bit   end_list;
    logic close;
    logic same;
    count  = 0;
    narrow = 1'($urandom_range(0, 1));
    n_cand = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
    foreach (qvec[k]) qvec[k] = rand_value(narrow);
    for (int i = 0; i < n_cand; i++) begin
      // mostly nominal length, sometimes a stray length
      cand_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len + 2) : len;
      kind     = $urandom_range(0, 9);
      for (int e = 0; e < cand_len; e++) begin
        case (kind)
          0:       c = qvec[e];
          1, 2, 3: c = qvec[e] + int'($urandom_range(0, 6)) - 3;
          default: c = rand_value(narrow);
        endcase
        end_cand = (e == cand_len - 1);
        end_list = end_cand && (i == n_cand - 1);
        close    = end_cand ? (end_list ? ($urandom_range(0, 3) != 0) : 1'b1) : 1'b0;
        same     = (end_cand && class_check_reg) ? ($urandom_range(0, 4) != 0)
                                                 : 1'($urandom_range(0, 1));
        push_pair(qvec[e], c, same, close, end_list,
                  (i == 0 && e == 0) ? ($urandom_range(0, 5) == 0) : 1'b0);
        count++;
      end
    end
    return count;
  endfunction

  task automatic wait_idle();
    while (pair_queue.size() != 0 || pending_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RATIO) ratio_reg = val[RATIO_W-1:0];
    else class_check_reg = val[0];
  endtask

  task automatic run_matches(input int budget);
    int queued = 0;
    while (queued < budget) queued += queue_random_list();
    wait_idle();
  endtask

  // stimulus sequence
  initial begin : stimulus
    while (rst) @(posedge clk);
    send_pct = 35;
    recv_pct = 54;

    // widest difference, single candidate against the all-ones second
    push_pair(32767, -32768, 1, 1, 1);
    // equal distances: the earlier candidate keeps best, the later becomes second
    push_pair(5, 2, 1, 1, 0);
    push_pair(2, 5, 0, 1, 0);
    push_pair(100, 90, 1, 1, 1);
    // list end closes the open candidate without its element mark
    push_pair(-32768, 32767, 1, 0, 0);
    push_pair(0, 0, 1, 1, 0);
    push_pair(7, 7, 1, 0, 1);
    // zero distance, class ignored
    push_pair(0, 0, 0, 1, 1);
    wait_idle();

    write_reg(REG_RATIO, 16'hFFFF);
    write_reg(REG_CLASS, 16'hFFFF);
    // every candidate of another class: nothing taken
    push_pair(1, 2, 0, 1, 0);
    push_pair(3, 4, 0, 1, 0);
    push_pair(5, 6, 1, 0, 0);
    push_pair(5, 6, 0, 1, 1);
    // skipped candidate still uses up an index
    push_pair(9, 9, 0, 1, 0);
    push_pair(4, 2, 1, 1, 0);
    push_pair(20, 10, 1, 1, 1);
    wait_idle();

    // zero ratio never passes
    write_reg(REG_RATIO, 16'h0000);
    write_reg(REG_CLASS, 16'hFFFE);
    push_pair(1, 0, 1, 1, 0);
    push_pair(-32768, -32768, 1, 1, 1);
    wait_idle();

    // random lists, sender lighter than receiver
    write_reg(REG_RATIO, RATIO_RESET);
    write_reg(REG_CLASS, 16'h0000);
    run_matches(135);
    write_reg(REG_RATIO, 16'hFFFF);
    write_reg(REG_CLASS, 16'h0001);
    run_matches(135);

    // swapped idling
    send_pct = 54;
    recv_pct = 35;
    write_reg(REG_RATIO, 16'h0000);
    write_reg(REG_CLASS, 16'h0000);
    run_matches(135);
    write_reg(REG_RATIO, 16'($urandom));
    write_reg(REG_CLASS, 16'($urandom) | 16'h0001);
    run_matches(135);

    // no idling
    send_pct = 0;
    recv_pct = 0;
    write_reg(REG_RATIO, 16'h0001);
    write_reg(REG_CLASS, 16'h0000);
    run_matches(130);
    write_reg(REG_RATIO, 16'($urandom));
    write_reg(REG_CLASS, 16'($urandom));
    run_matches(130);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
